// ----- design/sbus_frame_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// SBUS frame decoder assertion macros
// Shared property wrappers, clocked on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_DECODER_ASSERT_SVH
`define SBUS_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication
`define SBUSFD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sbus frame decoder: same-cycle check failed");

// Next-cycle implication
`define SBUSFD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sbus frame decoder: next-cycle check failed");

`endif

// ----- design/sbusfd_pkg.sv -----
// ----------------------------------------------------------------------------
// SBUS frame decoder package
// Frame layout constants, register indexes and the control bundle passed
// from the byte tracker to the channel unpacker.
// ----------------------------------------------------------------------------
package sbusfd_pkg;

	// Channels emitted per frame (8..16)
	localparam int NUM_CHANNELS = 16;

	// Frame layout
	localparam logic [7:0] SBUS_START  = 8'h0F;
	localparam int         FRAME_LEN   = 25;
	localparam int         STORE_LEN   = 23;
	localparam int         CH_W        = 11;
	localparam int         FRAME_W     = STORE_LEN * 8;
	localparam int         LOST_POS    = FRAME_W - 8 + 2;
	localparam int         FS_POS      = FRAME_W - 8 + 3;
	localparam logic [7:0] OVERRUN_GAP = 8'hFE;

	// Byte counter: holds 0..FRAME_LEN
	localparam int CNT_W = $clog2(FRAME_LEN + 1);
	localparam int IDX_W = 4;

	// Configuration port
	localparam int            CFG_IDX_W  = 1;
	localparam int            CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_START_GAP     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AUX_THRESHOLD = 1'd1;
	localparam logic [7:0]           START_GAP_RST     = 8'd80;
	localparam logic [CH_W-1:0]      AUX_THR_RST       = 11'd1600;

	// Tracker to unpacker
	typedef struct packed {
		logic       push;   // append a frame byte to the store
		logic [7:0] data;   // byte to append
		logic       start;  // frame complete: begin channel burst
	} ctl_t;

endpackage

// ----- design/sbusfd_unpack.sv -----
// ----------------------------------------------------------------------------
// SBUS channel unpacker
// Collects frame bytes in a shift store and, once a frame completes, shifts
// out one 11-bit channel per cycle while out_stall allows, through a shared
// shifter and comparator into the output register.
// ----------------------------------------------------------------------------
module sbusfd_unpack (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sbusfd_pkg::ctl_t            ctl,
	input  logic [sbusfd_pkg::CH_W-1:0] aux_threshold,
	output logic                        busy,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sbusfd_pkg::IDX_W-1:0] channel_index,
	output logic [sbusfd_pkg::CH_W-1:0] channel_value,
	output logic                        aux_high,
	output logic                        frame_lost,
	output logic                        failsafe_bit,
	output logic                        last
);

	localparam logic [sbusfd_pkg::IDX_W-1:0] LAST_CH =
		sbusfd_pkg::IDX_W'(sbusfd_pkg::NUM_CHANNELS - 1);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t                             state_q;
	logic [sbusfd_pkg::IDX_W-1:0]       ch_q;
	logic [sbusfd_pkg::FRAME_W-1:0]     frame_q;
	logic                               frm_lost_q;
	logic                               frm_fs_q;
	logic                               lost_q;
	logic                               fs_q;
	logic                               out_valid_q;
	logic [sbusfd_pkg::IDX_W-1:0]       index_q;
	logic [sbusfd_pkg::CH_W-1:0]        value_q;
	logic                               aux_q;
	logic                               last_q;
	logic [sbusfd_pkg::CH_W-1:0]        cur_ch;
	logic                               load;

	// Lowest channel of the store sits at the bottom bits
	assign cur_ch = frame_q[sbusfd_pkg::CH_W-1:0];
	assign load   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	// Frame store: append bytes while collecting, shift one channel per result
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			frame_q <= {ctl.data, frame_q[sbusfd_pkg::FRAME_W-1:8]};
		end else if (load) begin
			frame_q <= {{sbusfd_pkg::CH_W{1'b0}},
				frame_q[sbusfd_pkg::FRAME_W-1:sbusfd_pkg::CH_W]};
		end
	end

	// Burst sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
					// Keep the frame flags apart from a result still waiting
					if (ctl.start) begin
						frm_lost_q <= frame_q[sbusfd_pkg::LOST_POS];
						frm_fs_q   <= frame_q[sbusfd_pkg::FS_POS];
						ch_q       <= '0;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						index_q     <= ch_q;
						value_q     <= cur_ch;
						aux_q       <= (cur_ch > aux_threshold);
						lost_q      <= frm_lost_q;
						fs_q        <= frm_fs_q;
						last_q      <= (ch_q == LAST_CH);
						ch_q        <= ch_q + 1'b1;
						if (ch_q == LAST_CH) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q == ST_EMIT);
	assign out_valid     = out_valid_q;
	assign channel_index = index_q;
	assign channel_value = value_q;
	assign aux_high      = aux_q;
	assign frame_lost    = lost_q;
	assign failsafe_bit  = fs_q;
	assign last          = last_q;

endmodule

// ----- design/sbus_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// SBUS frame decoder
// Finds frame starts in a received byte stream, keeps the 23 payload bytes
// and emits the 16 packed 11-bit channels of each complete 25-byte frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in        sink       in_valid / in_stall  rx_byte, gap_ticks, overrun
//  out       source     out_valid/out_stall  channel_index .. last
//  cfg       sink       cfg_we               cfg_index, cfg_data
//
//  One byte is accepted per cycle while in_stall is low; the 25th byte of a
//  frame starts a burst of NUM_CHANNELS results, one per cycle from the
//  shared shift/compare unit while out_stall is low; the input is stalled
//  for the burst. The last result may wait in the output register while
//  new bytes arrive. Reset clears the frame tracker, restores both registers.
// ----------------------------------------------------------------------------
module sbus_frame_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        rx_byte,
	input  logic [7:0]                        gap_ticks,
	input  logic                              overrun,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sbusfd_pkg::IDX_W-1:0]      channel_index,
	output logic [sbusfd_pkg::CH_W-1:0]       channel_value,
	output logic                              aux_high,
	output logic                              frame_lost,
	output logic                              failsafe_bit,
	output logic                              last,
	input  logic                              cfg_we,
	input  logic [sbusfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sbusfd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam logic [sbusfd_pkg::CNT_W-1:0] CNT_ONE   = sbusfd_pkg::CNT_W'(1);
	localparam logic [sbusfd_pkg::CNT_W-1:0] CNT_FIRST = sbusfd_pkg::CNT_W'(2);
	localparam logic [sbusfd_pkg::CNT_W-1:0] CNT_STORE =
		sbusfd_pkg::CNT_W'(sbusfd_pkg::STORE_LEN + 1);
	localparam logic [sbusfd_pkg::CNT_W-1:0] CNT_FRAME =
		sbusfd_pkg::CNT_W'(sbusfd_pkg::FRAME_LEN);

	logic [7:0]                   start_gap_q;
	logic [sbusfd_pkg::CH_W-1:0]  aux_thr_q;
	logic [sbusfd_pkg::CNT_W-1:0] count_q;
	logic                         in_frame_q;
	logic [sbusfd_pkg::CNT_W-1:0] count_nxt;
	logic [7:0]                   eff_gap;
	logic                         is_start;
	logic                         in_acc;
	logic                         busy;
	sbusfd_pkg::ctl_t             ctl;

	// Qualify a start byte against the effective gap
	assign eff_gap   = overrun ? sbusfd_pkg::OVERRUN_GAP : gap_ticks;
	assign is_start  = (rx_byte == sbusfd_pkg::SBUS_START) && (eff_gap > start_gap_q);
	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = busy;
	assign count_nxt = count_q + 1'b1;

	// Route the request to the store or the burst sequencer
	always_comb begin
		ctl.push  = 1'b0;
		ctl.data  = rx_byte;
		ctl.start = 1'b0;
		if (in_acc && !is_start && in_frame_q) begin
			ctl.push  = (count_nxt >= CNT_FIRST) && (count_nxt <= CNT_STORE);
			ctl.start = (count_nxt == CNT_FRAME);
		end
	end

	// Track frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			in_frame_q <= 1'b0;
		end else if (in_acc) begin
			if (is_start) begin
				in_frame_q <= 1'b1;
				count_q    <= CNT_ONE;
			end else if (in_frame_q) begin
				count_q <= count_nxt;
				if (!ctl.push) begin
					in_frame_q <= 1'b0;
				end
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_gap_q <= sbusfd_pkg::START_GAP_RST;
			aux_thr_q   <= sbusfd_pkg::AUX_THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sbusfd_pkg::REG_START_GAP:     start_gap_q <= cfg_data[7:0];
				sbusfd_pkg::REG_AUX_THRESHOLD: aux_thr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	sbusfd_unpack u_unpack (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.aux_threshold (aux_thr_q),
		.busy          (busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.aux_high      (aux_high),
		.frame_lost    (frame_lost),
		.failsafe_bit  (failsafe_bit),
		.last          (last)
	);

`include "sbus_frame_decoder_assert.svh"

	// A completed frame blocks the input on the next cycle
	`SBUSFD_ASSERT_NXT(a_start_stalls, in_acc && ctl.start, in_stall)
	// While collecting, the count stays within the stored bytes
	`SBUSFD_ASSERT_IMP(a_count_range, in_frame_q, (count_q >= CNT_ONE) && (count_q <= CNT_STORE))
	// Outside a burst only the final result may be pending
	`SBUSFD_ASSERT_IMP(a_idle_last, out_valid && !in_stall, last)

endmodule
